// File: rtl/arxc_pkg.sv
// ----------------------------------------------------------------------------
// arxc_pkg
// Shared types, constants and half-round mix functions of the ARX cipher.
// ----------------------------------------------------------------------------
package arxc_pkg;

   localparam int unsigned WORD_W       = 32;
   localparam int unsigned BLOCK_WORDS  = 8;
   localparam int unsigned KEY_REG_W    = 64;
   localparam int unsigned NUM_KEY_REGS = 8;
   localparam int unsigned KEY_IDX_W    = 3;
   localparam int unsigned CSR_IDX_W    = 4;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_IN_01  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_IN_23  = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_IN_45  = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_IN_67  = 4'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_OUT_01 = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_OUT_23 = 4'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_OUT_45 = 4'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_OUT_67 = 4'd7;

   // Direction codes
   localparam logic MODE_ENCRYPT = 1'b0;
   localparam logic MODE_DECRYPT = 1'b1;

   // Shift distances of the mix
   localparam int unsigned SH_H = 8;
   localparam int unsigned SH_A = 8;
   localparam int unsigned SH_B = 11;
   localparam int unsigned SH_C = 3;
   localparam int unsigned SH_D = 6;
   localparam int unsigned SH_E = 4;
   localparam int unsigned SH_F = 13;
   localparam int unsigned SH_G = 13;

   typedef logic [WORD_W-1:0]                word_type;
   typedef word_type [BLOCK_WORDS-1:0]       block_type;
   typedef logic [KEY_REG_W-1:0]             key_reg_type;

   typedef struct packed {
      logic      mode;
      block_type data;
   } item_type;

   typedef struct packed {
      logic                 valid;
      logic [CSR_IDX_W-1:0] index;
      key_reg_type          data;
   } csr_write_type;

   // Forward round, first four steps
   function automatic block_type fwd_half0(block_type v);
      word_type a, b, c, d, e, f, g, h;
      block_type r;
      a = v[0]; b = v[1]; c = v[2]; d = v[3];
      e = v[4]; f = v[5]; g = v[6]; h = v[7];
      a = a - e; f = f ^ (h >> SH_H);  h = h + a;
      b = b - f; g = g ^ (a << SH_A);  a = a + b;
      c = c - g; h = h ^ (b >> SH_B);  b = b + c;
      d = d - h; a = a ^ (c << SH_C);  c = c + d;
      r[0] = a; r[1] = b; r[2] = c; r[3] = d;
      r[4] = e; r[5] = f; r[6] = g; r[7] = h;
      return r;
   endfunction

   // Forward round, last four steps
   function automatic block_type fwd_half1(block_type v);
      word_type a, b, c, d, e, f, g, h;
      block_type r;
      a = v[0]; b = v[1]; c = v[2]; d = v[3];
      e = v[4]; f = v[5]; g = v[6]; h = v[7];
      e = e - a; b = b ^ (d >> SH_D);  d = d + e;
      f = f - b; c = c ^ (e << SH_E);  e = e + f;
      g = g - c; d = d ^ (f >> SH_F);  f = f + g;
      h = h - d; e = e ^ (g << SH_G);  g = g + h;
      r[0] = a; r[1] = b; r[2] = c; r[3] = d;
      r[4] = e; r[5] = f; r[6] = g; r[7] = h;
      return r;
   endfunction

   // Inverse round, first four steps
   function automatic block_type inv_half0(block_type v);
      word_type a, b, c, d, e, f, g, h;
      block_type r;
      a = v[0]; b = v[1]; c = v[2]; d = v[3];
      e = v[4]; f = v[5]; g = v[6]; h = v[7];
      g = g - h; e = e ^ (g << SH_G);  h = h + d;
      f = f - g; d = d ^ (f >> SH_F);  g = g + c;
      e = e - f; c = c ^ (e << SH_E);  f = f + b;
      d = d - e; b = b ^ (d >> SH_D);  e = e + a;
      r[0] = a; r[1] = b; r[2] = c; r[3] = d;
      r[4] = e; r[5] = f; r[6] = g; r[7] = h;
      return r;
   endfunction

   // Inverse round, last four steps
   function automatic block_type inv_half1(block_type v);
      word_type a, b, c, d, e, f, g, h;
      block_type r;
      a = v[0]; b = v[1]; c = v[2]; d = v[3];
      e = v[4]; f = v[5]; g = v[6]; h = v[7];
      c = c - d; a = a ^ (c << SH_C);  d = d + h;
      b = b - c; h = h ^ (b >> SH_B);  c = c + g;
      a = a - b; g = g ^ (a << SH_A);  b = b + f;
      h = h - a; f = f ^ (h >> SH_H);  a = a + e;
      r[0] = a; r[1] = b; r[2] = c; r[3] = d;
      r[4] = e; r[5] = f; r[6] = g; r[7] = h;
      return r;
   endfunction

endpackage

// File: rtl/arxc_key_regs.sv
// ----------------------------------------------------------------------------
// arxc_key_regs
// Whitening key register file; splits each register into two key words.
// ----------------------------------------------------------------------------
module arxc_key_regs
   import arxc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  csr_write_type csr_wr,
   output block_type     key_in_words,
   output block_type     key_out_words
);

   key_reg_type key_ff [NUM_KEY_REGS];

   // Drop writes beyond the register list
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_KEY_REGS; i++) begin
            key_ff[i] <= '0;
         end
      end else if (csr_wr.valid && !csr_wr.index[CSR_IDX_W-1]) begin
         key_ff[csr_wr.index[KEY_IDX_W-1:0]] <= csr_wr.data;
      end
   end

   always_comb begin
      for (int i = 0; i < BLOCK_WORDS; i++) begin
         if (i % 2 == 1) begin
            key_in_words[i]  = key_ff[i / 2][KEY_REG_W-1:WORD_W];
            key_out_words[i] = key_ff[i / 2 + 4][KEY_REG_W-1:WORD_W];
         end else begin
            key_in_words[i]  = key_ff[i / 2][WORD_W-1:0];
            key_out_words[i] = key_ff[i / 2 + 4][WORD_W-1:0];
         end
      end
   end

endmodule

// File: rtl/arxc_half_round.sv
// ----------------------------------------------------------------------------
// arxc_half_round
// One registered pipeline stage: half of a forward or inverse round.
// ----------------------------------------------------------------------------
module arxc_half_round
   import arxc_pkg::*;
#(
   parameter bit HALF = 1'b0
)
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  item_type in_item,
   output logic     out_valid,
   output item_type out_item
);

   logic     valid_ff;
   item_type item_ff;
   item_type item_in;

   always_comb begin
      item_in.mode = in_item.mode;
      if (in_item.mode == MODE_DECRYPT) begin
         item_in.data = HALF ? inv_half1(in_item.data) : inv_half0(in_item.data);
      end else begin
         item_in.data = HALF ? fwd_half1(in_item.data) : fwd_half0(in_item.data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   // Payload advances every cycle; valid marks it
   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

// File: rtl/arx_block_cipher_256_core.sv
// ----------------------------------------------------------------------------
// arx_block_cipher_256_core
// Fully pipelined 256-bit ARX block cipher, encrypt and decrypt.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive req_mode and req_word_0..7 with start high; the
//   request is taken at a rising edge where start is high and busy is low.
//   busy is high only during reset, so one request is taken every cycle.
//   Result channel: rsp_valid strobes for exactly one cycle with
//   rsp_out_0..7; the receiver cannot stall, so results never wait.
//   Configuration: csr_valid/csr_ready write channel, csr_index selects
//   key_in_01..67 (0..3) or key_out_01..67 (4..7); other indexes are
//   dropped. csr_ready is always high. Write keys only while idle.
//   Pipeline: a taken request passes one input whitening stage, two
//   half-round stages per round and one output whitening stage, each a
//   register stage of its own, before its result shows on rsp_out_0..7.
//   Throughput: one block per clock, as no stage ever stalls.
//   Reset: synchronous, clears all keys and every stage valid bit, so any
//   block in flight is dropped.
// ----------------------------------------------------------------------------
module arx_block_cipher_256_core
   import arxc_pkg::*;
#(
   parameter int unsigned ROUNDS = 12
)
(
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 start,
   output logic                 busy,
   input  logic                 req_mode,
   input  logic [WORD_W-1:0]    req_word_0,
   input  logic [WORD_W-1:0]    req_word_1,
   input  logic [WORD_W-1:0]    req_word_2,
   input  logic [WORD_W-1:0]    req_word_3,
   input  logic [WORD_W-1:0]    req_word_4,
   input  logic [WORD_W-1:0]    req_word_5,
   input  logic [WORD_W-1:0]    req_word_6,
   input  logic [WORD_W-1:0]    req_word_7,
   // result channel
   output logic                 rsp_valid,
   output logic [WORD_W-1:0]    rsp_out_0,
   output logic [WORD_W-1:0]    rsp_out_1,
   output logic [WORD_W-1:0]    rsp_out_2,
   output logic [WORD_W-1:0]    rsp_out_3,
   output logic [WORD_W-1:0]    rsp_out_4,
   output logic [WORD_W-1:0]    rsp_out_5,
   output logic [WORD_W-1:0]    rsp_out_6,
   output logic [WORD_W-1:0]    rsp_out_7,
   // configuration write channel
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [KEY_REG_W-1:0] csr_data
);

   localparam int unsigned NUM_STAGES = 2 * ROUNDS;
   localparam int unsigned LATENCY    = NUM_STAGES + 2;

   csr_write_type csr_wr;
   block_type     key_in_words;
   block_type     key_out_words;
   block_type     req_block;
   block_type     first_key;
   block_type     last_key;
   logic          accept;

   logic          in_valid_ff;
   item_type      in_item_ff;
   item_type      in_item_in;

   logic          stage_valid [NUM_STAGES+1];
   item_type      stage_item  [NUM_STAGES+1];

   logic          rsp_valid_ff;
   block_type     rsp_block_ff;
   block_type     rsp_block_in;

   // Hold off requests only while in reset; the pipeline never stalls
   assign busy      = reset;
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   assign csr_wr.valid = csr_valid && csr_ready;
   assign csr_wr.index = csr_index;
   assign csr_wr.data  = csr_data;

   arxc_key_regs u_key_regs (
      .clock         (clock),
      .reset         (reset),
      .csr_wr        (csr_wr),
      .key_in_words  (key_in_words),
      .key_out_words (key_out_words)
   );

   assign req_block[0] = req_word_0;
   assign req_block[1] = req_word_1;
   assign req_block[2] = req_word_2;
   assign req_block[3] = req_word_3;
   assign req_block[4] = req_word_4;
   assign req_block[5] = req_word_5;
   assign req_block[6] = req_word_6;
   assign req_block[7] = req_word_7;

   // Decryption whitens with the output key first and the input key last
   assign first_key = (req_mode == MODE_DECRYPT) ? key_out_words : key_in_words;

   always_comb begin
      in_item_in.mode = req_mode;
      for (int i = 0; i < BLOCK_WORDS; i++) begin
         in_item_in.data[i] = req_block[i] ^ first_key[i];
      end
   end

   // Input whitening stage
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
   end

   assign stage_valid[0] = in_valid_ff;
   assign stage_item[0]  = in_item_ff;

   // Two half-round stages per round
   for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
      arxc_half_round #(
         .HALF (1'(k % 2))
      ) u_half_round (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[k]),
         .in_item   (stage_item[k]),
         .out_valid (stage_valid[k+1]),
         .out_item  (stage_item[k+1])
      );
   end

   // Output whitening stage, keyed by the mode carried with the block
   assign last_key = (stage_item[NUM_STAGES].mode == MODE_DECRYPT) ?
                     key_in_words : key_out_words;

   always_comb begin
      for (int i = 0; i < BLOCK_WORDS; i++) begin
         rsp_block_in[i] = stage_item[NUM_STAGES].data[i] ^ last_key[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= stage_valid[NUM_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      rsp_block_ff <= rsp_block_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_0 = rsp_block_ff[0];
   assign rsp_out_1 = rsp_block_ff[1];
   assign rsp_out_2 = rsp_block_ff[2];
   assign rsp_out_3 = rsp_block_ff[3];
   assign rsp_out_4 = rsp_block_ff[4];
   assign rsp_out_5 = rsp_block_ff[5];
   assign rsp_out_6 = rsp_block_ff[6];
   assign rsp_out_7 = rsp_block_ff[7];

`ifndef ASSERT_OFF
   // Every accepted request yields a result after the full pipeline depth
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##(LATENCY) rsp_valid)
      else $error("accepted request produced no result at pipeline depth");

   // No result appears without a request taken the pipeline depth earlier
   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LATENCY))
      else $error("result strobe without a matching request");

   // The last stage's mode is the mode of the request that entered it
   a_mode_carried: assert property (@(posedge clock) disable iff (reset)
      stage_valid[NUM_STAGES] |-> (stage_item[NUM_STAGES].mode ==
                                   $past(req_mode, NUM_STAGES + 1)))
      else $error("direction bit lost in the round pipeline");
`endif

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the pipelined 256-bit ARX cipher core. Requests are
// driven in bursts, mostly with random gaps; unpinned ones go through a local
// cipher model that keeps its own copy of the eight key registers. Each
// strobed result is compared word by word with the oldest outstanding block.
// ----------------------------------------------------------------------------
module testbench
   import arxc_pkg::*;
();

   localparam int unsigned CIPHER_ROUNDS = 12;
   localparam int unsigned DRAIN_CYCLES  = 2 * CIPHER_ROUNDS + 8;
   localparam int unsigned RANDOM_ITEMS  = 634;
   localparam int unsigned CYCLE_LIMIT   = 200000;
   localparam int unsigned REPORT_LIMIT  = 40;
   localparam int unsigned KEY_IDX_SPAN  = 2 ** CSR_IDX_W;
   localparam int unsigned DIR_ROWS      = 16;

   localparam block_type   BLK_ZERO = '0;
   localparam block_type   BLK_ONES = '1;
   localparam key_reg_type KEY_ONES = '1;

   // Register indexes in the order of the key map
   localparam logic [CSR_IDX_W-1:0] KEY_REG_IDX [NUM_KEY_REGS] = '{
      CSR_KEY_IN_01, CSR_KEY_IN_23, CSR_KEY_IN_45, CSR_KEY_IN_67,
      CSR_KEY_OUT_01, CSR_KEY_OUT_23, CSR_KEY_OUT_45, CSR_KEY_OUT_67
   };

   // One directed request; golden is used in place of the model when pinned
   typedef struct packed {
      logic      mode;
      block_type data;
      logic      pinned;
      block_type golden;
   } dir_row_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic                 req_mode;
   logic [WORD_W-1:0]    req_word_0, req_word_1, req_word_2, req_word_3;
   logic [WORD_W-1:0]    req_word_4, req_word_5, req_word_6, req_word_7;
   logic                 rsp_valid;
   logic [WORD_W-1:0]    rsp_out_0, rsp_out_1, rsp_out_2, rsp_out_3;
   logic [WORD_W-1:0]    rsp_out_4, rsp_out_5, rsp_out_6, rsp_out_7;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [KEY_REG_W-1:0] csr_data;

   // Golden value travelling alongside a directed request
   logic                 pin_valid;
   block_type            pin_block;

   key_reg_type          key_shadow [NUM_KEY_REGS];
   block_type            pending_blocks [$];
   dir_row_type          dir_table [DIR_ROWS];

   int unsigned          cycle_count   = 0;
   int unsigned          fail_count    = 0;
   int unsigned          accepted      = 0;
   int unsigned          decrypted     = 0;
   int unsigned          dropped_csr   = 0;
   int unsigned          key_settings  = 0;
   int unsigned          burst_left    = 0;
   bit                   gaps_on       = 1'b1;

   arx_block_cipher_256_core #(
      .ROUNDS (CIPHER_ROUNDS)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_mode   (req_mode),
      .req_word_0 (req_word_0),
      .req_word_1 (req_word_1),
      .req_word_2 (req_word_2),
      .req_word_3 (req_word_3),
      .req_word_4 (req_word_4),
      .req_word_5 (req_word_5),
      .req_word_6 (req_word_6),
      .req_word_7 (req_word_7),
      .rsp_valid  (rsp_valid),
      .rsp_out_0  (rsp_out_0),
      .rsp_out_1  (rsp_out_1),
      .rsp_out_2  (rsp_out_2),
      .rsp_out_3  (rsp_out_3),
      .rsp_out_4  (rsp_out_4),
      .rsp_out_5  (rsp_out_5),
      .rsp_out_6  (rsp_out_6),
      .rsp_out_7  (rsp_out_7),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // Cipher model
   // ------------------------------------------------------------------------

   // Pick key word i of the half starting at register base; even words sit
   // in the low half of a register
   function automatic word_type key_word(int base, int i);
      key_reg_type r;
      r = key_shadow[base + i / 2];
      return (i % 2 != 0) ? r[63:32] : r[31:0];
   endfunction

   function automatic block_type round_forward(block_type v);
      word_type a, b, c, d, e, f, g, h;
      a = v[0]; b = v[1]; c = v[2]; d = v[3];
      e = v[4]; f = v[5]; g = v[6]; h = v[7];
      a -= e; f ^= h >> 8;  h += a;
      b -= f; g ^= a << 8;  a += b;
      c -= g; h ^= b >> 11; b += c;
      d -= h; a ^= c << 3;  c += d;
      e -= a; b ^= d >> 6;  d += e;
      f -= b; c ^= e << 4;  e += f;
      g -= c; d ^= f >> 13; f += g;
      h -= d; e ^= g << 13; g += h;
      return {h, g, f, e, d, c, b, a};
   endfunction

   // Undo round_forward step by step, last step first
   function automatic block_type round_inverse(block_type v);
      word_type a, b, c, d, e, f, g, h;
      a = v[0]; b = v[1]; c = v[2]; d = v[3];
      e = v[4]; f = v[5]; g = v[6]; h = v[7];
      g -= h; e ^= g << 13; h += d;
      f -= g; d ^= f >> 13; g += c;
      e -= f; c ^= e << 4;  f += b;
      d -= e; b ^= d >> 6;  e += a;
      c -= d; a ^= c << 3;  d += h;
      b -= c; h ^= b >> 11; c += g;
      a -= b; g ^= a << 8;  b += f;
      h -= a; f ^= h >> 8;  a += e;
      return {h, g, f, e, d, c, b, a};
   endfunction

   // Whiten, run the rounds in the chosen direction, whiten again
   function automatic block_type predict_cipher(logic mode, block_type blk);
      block_type v;
      int        first;
      int        last;
      first = (mode == MODE_DECRYPT) ? 4 : 0;
      last  = (mode == MODE_DECRYPT) ? 0 : 4;
      for (int i = 0; i < BLOCK_WORDS; i++) v[i] = blk[i] ^ key_word(first, i);
      for (int r = 0; r < CIPHER_ROUNDS; r++) begin
         if (mode == MODE_DECRYPT) v = round_inverse(v);
         else v = round_forward(v);
      end
      for (int i = 0; i < BLOCK_WORDS; i++) v[i] = v[i] ^ key_word(last, i);
      return v;
   endfunction

   // ------------------------------------------------------------------------
   // Monitor: check results, track key writes and log accepted requests.
   // All of it lives in one process so that nothing depends on the order in
   // which processes wake at a clock edge.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      block_type got;
      block_type want;
      if (reset) begin
         for (int k = 0; k < NUM_KEY_REGS; k++) key_shadow[k] = '0;
      end else begin
         // Compare a strobed result with the oldest outstanding block
         if (rsp_valid) begin
            got = {rsp_out_7, rsp_out_6, rsp_out_5, rsp_out_4,
                   rsp_out_3, rsp_out_2, rsp_out_1, rsp_out_0};
            if (pending_blocks.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display("%0t: result %h arrived with no request outstanding",
                           $time, got);
            end else begin
               want = pending_blocks.pop_front();
               for (int i = 0; i < BLOCK_WORDS; i++) begin
                  if (got[i] !== want[i]) begin
                     fail_count++;
                     if (fail_count <= REPORT_LIMIT)
                        $display("%0t: out_%0d expected %h actual %h",
                                 $time, i, want[i], got[i]);
                  end
               end
            end
         end
         // Predict the result of a request taken at this edge
         if (start && !busy) begin
            pending_blocks.push_back(pin_valid ? pin_block :
               predict_cipher(req_mode, {req_word_7, req_word_6, req_word_5,
                                         req_word_4, req_word_3, req_word_2,
                                         req_word_1, req_word_0}));
            accepted++;
            if (req_mode == MODE_DECRYPT) decrypted++;
         end
         // Mirror key writes; indexes past the key map are dropped
         if (csr_valid && csr_ready) begin
            if (csr_index < NUM_KEY_REGS)
               key_shadow[csr_index[KEY_IDX_W-1:0]] = csr_data;
            else dropped_csr++;
         end
      end
   end

   // Hard stop in case the core hangs or loses a result
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timed out with %0d blocks outstanding",
                  $time, pending_blocks.size());
         $display("[arx_block_cipher_256_core] ERROR");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Drivers. Inputs change on the falling edge only, once per edge.
   // ------------------------------------------------------------------------

   // Hold the request channel idle; n gives the length of the idle span
   task automatic hold_off(int unsigned n);
      repeat (n) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   // Present one request and wait until it is taken; start stays high
   // afterwards so that a back-to-back request needs no second assignment
   task automatic issue_block(logic mode, block_type blk, logic pinned,
                              block_type golden);
      if (gaps_on && burst_left == 0) begin
         hold_off($urandom_range(1, 8));
         burst_left = $urandom_range(1, 16);
      end
      if (burst_left != 0) burst_left--;
      @(negedge clock);
      start      <= 1'b1;
      req_mode   <= mode;
      req_word_0 <= blk[0];
      req_word_1 <= blk[1];
      req_word_2 <= blk[2];
      req_word_3 <= blk[3];
      req_word_4 <= blk[4];
      req_word_5 <= blk[5];
      req_word_6 <= blk[6];
      req_word_7 <= blk[7];
      pin_valid  <= pinned;
      pin_block  <= golden;
      do @(posedge clock); while (busy);
   endtask

   task automatic write_key(logic [CSR_IDX_W-1:0] idx, key_reg_type value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic release_csr();
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Drop start and wait until every outstanding block has come back
   task automatic wait_drained();
      hold_off(1);
      while (pending_blocks.size() != 0) @(negedge clock);
   endtask

   // Load a fresh key setting: all ones first, then a half-zero, half-ones
   // split, then random mixes of zero, all-ones and random registers. Each
   // setting also carries one write to an index past the key map.
   task automatic load_keys(int unsigned phase);
      key_reg_type value;
      for (int k = 0; k < NUM_KEY_REGS; k++) begin
         if (phase == 0) value = KEY_ONES;
         else if (phase == 1) value = (k < NUM_KEY_REGS / 2) ? '0 : KEY_ONES;
         else begin
            case ($urandom_range(0, 5))
               0:       value = '0;
               1:       value = KEY_ONES;
               default: value = {$urandom(), $urandom()};
            endcase
         end
         if (phase < 2 || $urandom_range(0, 3) != 0) write_key(KEY_REG_IDX[k], value);
      end
      write_key(CSR_IDX_W'($urandom_range(NUM_KEY_REGS, KEY_IDX_SPAN - 1)),
                {$urandom(), $urandom()});
      release_csr();
      key_settings++;
   endtask

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   initial begin
      int unsigned random_sent;
      int unsigned phase;
      int unsigned n_items;
      logic        mode;
      block_type   blk;

      reset      <= 1'b1;
      start      <= 1'b0;
      req_mode   <= MODE_ENCRYPT;
      req_word_0 <= '0;
      req_word_1 <= '0;
      req_word_2 <= '0;
      req_word_3 <= '0;
      req_word_4 <= '0;
      req_word_5 <= '0;
      req_word_6 <= '0;
      req_word_7 <= '0;
      pin_valid  <= 1'b0;
      pin_block  <= '0;
      csr_valid  <= 1'b0;
      csr_index  <= '0;
      csr_data   <= '0;

      // Directed requests. With every key at zero the all-zero block is a
      // fixed point of the mix in both directions; the rest go to the model.
      dir_table = '{
         {MODE_ENCRYPT, BLK_ZERO, 1'b1, BLK_ZERO},
         {MODE_DECRYPT, BLK_ZERO, 1'b1, BLK_ZERO},
         {MODE_ENCRYPT, BLK_ONES, 1'b0, BLK_ZERO},
         {MODE_DECRYPT, BLK_ONES, 1'b0, BLK_ZERO},
         {MODE_ENCRYPT, {8{32'hAAAA_AAAA}}, 1'b0, BLK_ZERO},
         {MODE_DECRYPT, {8{32'h5555_5555}}, 1'b0, BLK_ZERO},
         {MODE_ENCRYPT, {{7{32'h0}}, 32'hFFFF_FFFF}, 1'b0, BLK_ZERO},
         {MODE_DECRYPT, {32'hFFFF_FFFF, {7{32'h0}}}, 1'b0, BLK_ZERO},
         {MODE_ENCRYPT, {8{32'h8000_0000}}, 1'b0, BLK_ZERO},
         {MODE_DECRYPT, {8{32'h0000_0001}}, 1'b0, BLK_ZERO},
         {MODE_ENCRYPT, {8{32'h0000_0001}}, 1'b0, BLK_ZERO},
         {MODE_DECRYPT, {8{32'h8000_0000}}, 1'b0, BLK_ZERO},
         {MODE_ENCRYPT, {32'd7, 32'd6, 32'd5, 32'd4, 32'd3, 32'd2, 32'd1, 32'd0},
          1'b0, BLK_ZERO},
         {MODE_DECRYPT, {32'd7, 32'd6, 32'd5, 32'd4, 32'd3, 32'd2, 32'd1, 32'd0},
          1'b0, BLK_ZERO},
         {MODE_ENCRYPT, {4{32'hFFFF_FFFF, 32'h0}}, 1'b0, BLK_ZERO},
         {MODE_DECRYPT, {4{32'h0, 32'hFFFF_FFFF}}, 1'b0, BLK_ZERO}
      };

      // Hold reset, then release it on a falling edge
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // A write past the key map must leave the zero keys alone, so the
      // pinned all-zero rows below still hold
      write_key(CSR_IDX_W'(KEY_IDX_SPAN - 1), KEY_ONES);
      release_csr();

      for (int r = 0; r < DIR_ROWS; r++)
         issue_block(dir_table[r].mode, dir_table[r].data,
                     dir_table[r].pinned, dir_table[r].golden);
      wait_drained();

      // Random part, one key setting per phase; every third phase runs
      // without gaps so the pipeline also sees long unbroken streams
      random_sent = 0;
      phase = 0;
      while (random_sent < RANDOM_ITEMS) begin
         load_keys(phase);
         gaps_on    = (phase % 3) != 2;
         burst_left = 0;
         n_items    = $urandom_range(40, 110);
         if (n_items > RANDOM_ITEMS - random_sent) n_items = RANDOM_ITEMS - random_sent;
         repeat (n_items) begin
            mode = $urandom_range(0, 1) ? MODE_DECRYPT : MODE_ENCRYPT;
            for (int i = 0; i < BLOCK_WORDS; i++) begin
               case ($urandom_range(0, 7))
                  0:       blk[i] = '0;
                  1:       blk[i] = '1;
                  default: blk[i] = $urandom();
               endcase
            end
            issue_block(mode, blk, 1'b0, BLK_ZERO);
            random_sent++;
         end
         wait_drained();
         phase++;
      end

      // Let any stray result surface before the verdict
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Ran %0d blocks (%0d decrypted) under %0d key settings.",
               accepted, decrypted, key_settings + 1);
      $display("Dropped %0d key writes to indexes past the key map.", dropped_csr);
      if (fail_count == 0 && pending_blocks.size() == 0) begin
         $display("[arx_block_cipher_256_core] OK");
      end else begin
         $display("[arx_block_cipher_256_core] ERROR");
      end
      $finish;
   end

endmodule

// File: arx_block_cipher_256_core.f
rtl/arxc_pkg.sv
rtl/arxc_key_regs.sv
rtl/arxc_half_round.sv
rtl/arx_block_cipher_256_core.sv
tb/testbench.sv
